@@ design/nll_pkg.sv @@
package nll_pkg;

  typedef struct packed {
    logic signed [31:0] sample_in;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_out;
    logic               last_out;
  } out_item_t;

  localparam logic [1:0] RegStageGain    = 2'd0;
  localparam logic [1:0] RegFeedbackGain = 2'd1;
  localparam logic [1:0] RegThermalGain  = 2'd2;

  localparam logic [31:0] StageGainReset    = 32'd163754803;
  localparam logic [31:0] FeedbackGainReset = 32'd221930624;
  localparam logic [31:0] ThermalGainReset  = 32'd107374;

  localparam int TanhStepBits = 21;
  localparam logic [23:0] TanhEnd = 24'd8382982;

  // odd tanh table, Q1.23, steps of 1/8 over [0,4]
  function automatic logic [23:0] tanh_point(input logic [5:0] idx);
    logic [23:0] r;
    case (idx)
      6'd0: r = 24'd0;        6'd1: r = 24'd1043149;  6'd2: r = 24'd2054527;
      6'd3: r = 24'd3006120;  6'd4: r = 24'd3876520;  6'd5: r = 24'd4652320;
      6'd6: r = 24'd5328016;  6'd7: r = 24'd5904788;  6'd8: r = 24'd6388715;
      6'd9: r = 24'd6788909;  6'd10: r = 24'd7115919; 6'd11: r = 24'd7380521;
      6'd12: r = 24'd7592934; 6'd13: r = 24'd7762367; 6'd14: r = 24'd7896829;
      6'd15: r = 24'd8003112; 6'd16: r = 24'd8086849; 6'd17: r = 24'd8152659;
      6'd18: r = 24'd8204278; 6'd19: r = 24'd8244701; 6'd20: r = 24'd8276321;
      6'd21: r = 24'd8301028; 6'd22: r = 24'd8320322; 6'd23: r = 24'd8335379;
      6'd24: r = 24'd8347124; 6'd25: r = 24'd8356282; 6'd26: r = 24'd8363422;
      6'd27: r = 24'd8368987; 6'd28: r = 24'd8373323; 6'd29: r = 24'd8376701;
      6'd30: r = 24'd8379334; 6'd31: r = 24'd8381385; default: r = TanhEnd;
    endcase
    return r;
  endfunction

endpackage

@@ design/nonlinear_ladder_lowpass.sv @@
// Four-pole nonlinear ladder lowpass: tanh saturation in every stage and
// resonance feedback from the half-sample compensated output.
// Input channel: in_valid_i / in_stall_o carry in_data_i (sample_in Q8.24,
// last_in); a transaction completes when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry out_data_o (filtered Q8.24
// sample, copied last flag); one result transaction per input transaction.
// Config: cfg_valid_i / cfg_ready_o with cfg_index_i, cfg_data_i; ready only
// while idle. Index 0 stage gain, 1 feedback gain, 2 thermal gain; other
// indexes are ignored.
// Schedule: a sub-step is 20 sequencer steps on one shared 33x33 multiplier
// (one feedback product, five tanh arguments, four stage updates) with one
// shared tanh table lookup; a sample runs OVERSAMPLE sub-steps. The input
// stays stalled from an accepted sample until its result is loaded into the
// output register. The next sample is taken while a result waits in the
// output register; when the receiver stalls, the following result waits and
// the input stays stalled until the output register frees up.
// Reset clears all filter state and loads the register defaults.
module nonlinear_ladder_lowpass #(
  parameter int unsigned OVERSAMPLE = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nll_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nll_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int SubW = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;

  // sequencer steps within one sub-step
  localparam logic [4:0] StepFb      = 5'd0;   // feedback product
  localparam logic [4:0] StepDrive   = 5'd1;   // input minus feedback
  localparam logic [4:0] StepArg0    = 5'd2;   // tanh argument of drive
  localparam logic [4:0] StepLut0    = 5'd3;
  localparam logic [4:0] StepMul0    = 5'd4;   // stage 0 gain product
  localparam logic [4:0] StepUpd0    = 5'd5;
  localparam logic [4:0] StepArg1    = 5'd6;   // tanh argument of stage 0
  localparam logic [4:0] StepLut1    = 5'd7;
  localparam logic [4:0] StepMul1    = 5'd8;
  localparam logic [4:0] StepUpd1    = 5'd9;
  localparam logic [4:0] StepArg2    = 5'd10;
  localparam logic [4:0] StepLut2    = 5'd11;
  localparam logic [4:0] StepMul2    = 5'd12;
  localparam logic [4:0] StepUpd2    = 5'd13;
  localparam logic [4:0] StepArg3    = 5'd14;  // tanh argument of stage 2
  localparam logic [4:0] StepLut3    = 5'd15;
  localparam logic [4:0] StepArgLast = 5'd16;  // tanh argument of old stage 3
  localparam logic [4:0] StepLutLast = 5'd17;
  localparam logic [4:0] StepMul3    = 5'd18;
  localparam logic [4:0] StepUpd3    = 5'd19;  // also output compensation

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    RUN  = 3'b010,
    DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [31:0] sg_q, fg_q, tg_q;
  logic signed [31:0] st_q [4];
  logic signed [23:0] th_q [3];
  logic signed [31:0] prev_q, comp_q, smp_q, x_q;
  logic signed [23:0] t_q;       // latest tanh value
  logic [4:0] step_q;
  logic [SubW-1:0] sub_q;
  logic last_q;
  logic signed [65:0] prod_q;    // registered shared product
  logic out_valid_q, out_valid_d;
  nll_pkg::out_item_t out_q;
  logic out_free;
  logic last_step;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mul;
  logic signed [31:0] diff;
  logic signed [31:0] ucur;
  logic signed [31:0] upd;
  logic signed [31:0] drive;
  logic signed [32:0] csum;
  logic signed [23:0] tanh_y;

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // tanh of the registered product, argument = floor(prod/2^32)
  always_comb begin
    logic signed [31:0] arg;
    logic [31:0] mag;
    logic [5:0] idx;
    logic [23:0] lo, hi, y;
    logic [44:0] p;
    arg  = prod_q[63:32];
    mag  = arg[31] ? -arg : arg;
    idx  = (mag[31:26] != '0) ? 6'd32 : {1'b0, mag[25:21]};
    lo   = nll_pkg::tanh_point(idx);
    hi   = nll_pkg::tanh_point(idx + 6'd1);
    p    = 45'(hi - lo) * 45'(mag[20:0]);
    y    = (idx == 6'd32) ? nll_pkg::TanhEnd : lo + 24'(p >> nll_pkg::TanhStepBits);
    tanh_y = arg[31] ? -$signed(y) : $signed(y);
  end

  // tanh difference feeding each stage update
  always_comb begin
    case (step_q)
      StepMul0: diff = 32'(t_q) - 32'(th_q[0]);
      StepMul1: diff = 32'(t_q) - 32'(th_q[1]);
      StepMul2: diff = 32'(t_q) - 32'(th_q[2]);
      default:  diff = 32'(th_q[2]) - 32'(t_q);
    endcase
  end

  always_comb begin
    case (step_q)
      StepUpd0: ucur = st_q[0];
      StepUpd1: ucur = st_q[1];
      StepUpd2: ucur = st_q[2];
      default:  ucur = st_q[3];
    endcase
  end

  assign upd   = sat(66'(ucur) + (prod_q >>> 15));
  assign drive = sat(66'(smp_q) - (prod_q >>> 29));
  assign csum  = 33'(upd) + 33'(prev_q);

  // shared multiplier: unsigned gain times signed value
  always_comb begin
    ma = {1'b0, sg_q};
    mb = {diff[31], diff};
    case (step_q)
      StepFb: begin
        ma = {1'b0, fg_q};
        mb = {comp_q[31], comp_q};
      end
      StepArg0: begin
        ma = {1'b0, tg_q};
        mb = {x_q[31], x_q};
      end
      StepArg1: begin
        ma = {1'b0, tg_q};
        mb = {st_q[0][31], st_q[0]};
      end
      StepArg2: begin
        ma = {1'b0, tg_q};
        mb = {st_q[1][31], st_q[1]};
      end
      StepArg3: begin
        ma = {1'b0, tg_q};
        mb = {st_q[2][31], st_q[2]};
      end
      StepArgLast: begin
        ma = {1'b0, tg_q};
        mb = {st_q[3][31], st_q[3]};
      end
      default: ;
    endcase
  end

  assign mul = 66'(ma) * 66'(mb);

  assign in_stall_o  = (state_q != IDLE);
  assign cfg_ready_o = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = (step_q == StepUpd3) && (sub_q == SubW'(OVERSAMPLE - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      IDLE: if (in_valid_i) state_d = RUN;
      RUN:  if (last_step) state_d = DONE;
      DONE: if (out_free) state_d = IDLE;
      default: state_d = IDLE;
    endcase
  end

  // DONE either loads a free output register or holds a stalled one
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (state_q == DONE) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      sg_q <= nll_pkg::StageGainReset;
      fg_q <= nll_pkg::FeedbackGainReset;
      tg_q <= nll_pkg::ThermalGainReset;
      for (int i = 0; i < 4; i++) st_q[i] <= '0;
      for (int i = 0; i < 3; i++) th_q[i] <= '0;
      prev_q <= '0; comp_q <= '0; smp_q <= '0; x_q <= '0; t_q <= '0;
      step_q <= '0; sub_q <= '0; last_q <= 1'b0;
      prod_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nll_pkg::RegStageGain:    sg_q <= cfg_data_i;
          nll_pkg::RegFeedbackGain: fg_q <= cfg_data_i;
          nll_pkg::RegThermalGain:  tg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        smp_q <= in_data_i.sample_in;
        last_q <= in_data_i.last_in;
        step_q <= '0;
        sub_q <= '0;
      end
      if (state_q == RUN) begin
        case (step_q)
          StepFb, StepArg0, StepMul0, StepArg1, StepMul1, StepArg2, StepMul2,
          StepArg3, StepArgLast, StepMul3: prod_q <= mul;
          StepDrive: x_q <= drive;
          StepLut0: t_q <= tanh_y;
          StepLut1: begin
            t_q <= tanh_y;
            th_q[0] <= tanh_y;
          end
          StepLut2: begin
            t_q <= tanh_y;
            th_q[1] <= tanh_y;
          end
          StepLut3: th_q[2] <= tanh_y;
          StepLutLast: t_q <= tanh_y;
          StepUpd0: st_q[0] <= upd;
          StepUpd1: st_q[1] <= upd;
          StepUpd2: st_q[2] <= upd;
          StepUpd3: begin
            st_q[3] <= upd;
            prev_q <= upd;
            comp_q <= csum[32:1];  // floor of the half sum
          end
          default: ;
        endcase
        if (step_q == StepUpd3) begin
          step_q <= '0;
          sub_q <= sub_q + SubW'(1);
        end else begin
          step_q <= step_q + 5'd1;
        end
      end
      if (state_q == DONE && out_free) begin
        out_q.sample_out <= comp_q;
        out_q.last_out <= last_q;
      end
    end
  end

endmodule

@@ design/nll_checker.sv @@
module nll_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic cfg_ready_o
);
  // one sample in flight: after an accepted transaction the input stalls
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("accepted while busy");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == !in_stall_o) else $error("cfg ready mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
endmodule

bind nonlinear_ladder_lowpass nll_checker u_nll_checker (.*);
